[design/set_assoc_cache_tag_controller_assert.svh]
// Assertion macros used by the checker of the tag controller.
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SACTC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tag controller check failed");

// next-cycle implication
`define SACTC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tag controller check failed");

`endif

[design/sactc_pkg.sv]
// Types and constants of the set-associative cache tag controller.
package sactc_pkg;

   localparam int ADDR_W     = 32;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FETCH = 2'd2;

   localparam logic [1:0] KIND_INSTR   = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_UNIFIED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_WAYS_IN_USE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_BITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SET_BITS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_ALLOCATE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CACHE_KIND     = 3'd4;

   typedef struct packed {
      logic [3:0] ways_in_use;
      logic [2:0] offset_bits;
      logic [3:0] set_bits;
      logic       write_allocate;
      logic [1:0] cache_kind;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      ways_in_use:    4'd1,
      offset_bits:    3'd2,
      set_bits:       4'd0,
      write_allocate: 1'b1,
      cache_kind:     KIND_UNIFIED
   };

   typedef struct packed {
      logic              accepted;
      logic              hit;
      logic              writeback_valid;
      logic [ADDR_W-1:0] writeback_address;
   } rsp_type;

endpackage

[design/set_assoc_cache_tag_controller.sv]
// Top level of the set-associative write-back cache tag controller.
//
// req channel: one beat per access (command, byte address). rsp channel: one
// beat per access (accepted, hit, write-back of a dirty victim and its line
// address), in request order. csr channel: register writes, always ready;
// write only while no access is in flight.
// An access is accepted in IDLE; its set row is read from the tag and meta
// memories at that edge. In LOOKUP the ways are compared and, once the output
// register is free, the row is written back while the result enters the
// output register. A new access is taken only once the current one has left
// LOOKUP, as set by the read-then-write of the set row.
// The output register lets a new access be taken while a result waits; the
// following lookup holds until the output register is free, so a stalled
// receiver stops the block after one more accepted beat.
// Reset: a clearing pass writes every meta row (valid, dirty, pointer) to
// zero, one row a cycle, 2**SET_AW rows (256 by default); req_ready is low
// for its duration. Configuration registers return to their reset values.
module set_assoc_cache_tag_controller #(
   parameter int MAX_WAYS = 8,
   parameter int MAX_SETS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [sactc_pkg::ADDR_W-1:0]        req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_hit,
   output logic                                rsp_writeback_valid,
   output logic [sactc_pkg::ADDR_W-1:0]        rsp_writeback_address,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sactc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sactc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PTR_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS+1);
   localparam int SET_IDX_W = $clog2(MAX_SETS+1) - 1;
   localparam int SET_AW    = (SET_IDX_W > 0) ? SET_IDX_W : 1;
   localparam int ROWS      = 2**SET_AW;
   localparam int META_W    = PTR_W + 2*MAX_WAYS;
   localparam int AW        = sactc_pkg::ADDR_W;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_LOOKUP = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [SET_AW-1:0]        clr_cnt_ff, clr_cnt_in;
   sactc_pkg::cfg_type       cfg_ff, cfg_in;
   logic [1:0]               cmd_ff;
   logic [SET_AW-1:0]        set_ff;
   logic [AW-1:0]            tag_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   sactc_pkg::rsp_type       rsp_ff;

   logic [4:0]               ways_sat;
   logic [WAY_CNT_W-1:0]     eff_ways;
   logic [3:0]               eff_sb;
   logic [sactc_pkg::SHIFT_W-1:0] shift;
   logic [AW-1:0]            set_mask;
   logic [AW-1:0]            set_full;
   logic                     req_fire;
   logic                     advance;

   logic [0:0][META_W-1:0]   meta_rd;
   logic [0:0][META_W-1:0]   meta_wdata;
   logic                     meta_wr_en;
   logic [SET_AW-1:0]        meta_wr_addr;
   logic [MAX_WAYS-1:0][AW-1:0] tag_rd;
   logic [MAX_WAYS-1:0][AW-1:0] tag_wdata;

   logic                     meta_we;
   logic [MAX_WAYS-1:0]      valid_new;
   logic [MAX_WAYS-1:0]      dirty_new;
   logic [PTR_W-1:0]         ptr_new;
   logic [MAX_WAYS-1:0]      tag_we;
   sactc_pkg::rsp_type       res;

   // effective configuration
   always_comb begin
      if (cfg_ff.ways_in_use == 4'd0) begin
         ways_sat = 5'd1;
      end else if ({1'b0, cfg_ff.ways_in_use} > 5'(MAX_WAYS)) begin
         ways_sat = 5'(MAX_WAYS);
      end else begin
         ways_sat = {1'b0, cfg_ff.ways_in_use};
      end
      eff_ways = WAY_CNT_W'(ways_sat);
      eff_sb   = (cfg_ff.set_bits > 4'(SET_IDX_W)) ? 4'(SET_IDX_W) : cfg_ff.set_bits;
      shift    = {2'b00, cfg_ff.offset_bits} + {1'b0, eff_sb};
      set_mask = (AW'(1) << eff_sb) - AW'(1);
      set_full = (req_address >> cfg_ff.offset_bits) & set_mask;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign advance   = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + SET_AW'(1);
            if (clr_cnt_ff == {SET_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (advance) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sactc_pkg::REG_WAYS_IN_USE:    cfg_in.ways_in_use    = csr_wdata[3:0];
            sactc_pkg::REG_OFFSET_BITS:    cfg_in.offset_bits    = csr_wdata[2:0];
            sactc_pkg::REG_SET_BITS:       cfg_in.set_bits       = csr_wdata[3:0];
            sactc_pkg::REG_WRITE_ALLOCATE: cfg_in.write_allocate = csr_wdata[0];
            sactc_pkg::REG_CACHE_KIND:     cfg_in.cache_kind     = csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         cfg_ff       <= sactc_pkg::CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_command;
         set_ff <= set_full[SET_AW-1:0];
         tag_ff <= req_address >> shift;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   // meta row: {pointer, dirty, valid}
   assign meta_wr_en   = (state_ff == ST_CLEAR) || (advance && meta_we);
   assign meta_wr_addr = (state_ff == ST_CLEAR) ? clr_cnt_ff : set_ff;
   assign meta_wdata   = (state_ff == ST_CLEAR) ? '0 : {ptr_new, dirty_new, valid_new};
   assign tag_wdata    = {MAX_WAYS{tag_ff}};

   sactc_ram #(
      .DEPTH  (ROWS),
      .AW     (SET_AW),
      .LANES  (1),
      .LANE_W (META_W)
   ) u_meta_ram (
      .clock      (clock),
      .wr_en      (meta_wr_en),
      .wr_addr    (meta_wr_addr),
      .wr_mask    (1'b1),
      .wr_data    (meta_wdata),
      .rd_en      (req_fire),
      .rd_addr    (set_full[SET_AW-1:0]),
      .rd_data_ff (meta_rd)
   );

   sactc_ram #(
      .DEPTH  (ROWS),
      .AW     (SET_AW),
      .LANES  (MAX_WAYS),
      .LANE_W (AW)
   ) u_tag_ram (
      .clock      (clock),
      .wr_en      (advance),
      .wr_addr    (set_ff),
      .wr_mask    (tag_we),
      .wr_data    (tag_wdata),
      .rd_en      (req_fire),
      .rd_addr    (set_full[SET_AW-1:0]),
      .rd_data_ff (tag_rd)
   );

   sactc_decide #(
      .MAX_WAYS (MAX_WAYS),
      .SET_AW   (SET_AW)
   ) u_decide (
      .command   (cmd_ff),
      .cfg       (cfg_ff),
      .eff_ways  (eff_ways),
      .shift     (shift),
      .tag       (tag_ff),
      .set_idx   (set_ff),
      .valid_row (meta_rd[0][MAX_WAYS-1:0]),
      .dirty_row (meta_rd[0][2*MAX_WAYS-1:MAX_WAYS]),
      .ptr       (meta_rd[0][META_W-1:2*MAX_WAYS]),
      .tag_row   (tag_rd),
      .meta_we   (meta_we),
      .valid_new (valid_new),
      .dirty_new (dirty_new),
      .ptr_new   (ptr_new),
      .tag_we    (tag_we),
      .res       (res)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_accepted          = rsp_ff.accepted;
   assign rsp_hit               = rsp_ff.hit;
   assign rsp_writeback_valid   = rsp_ff.writeback_valid;
   assign rsp_writeback_address = rsp_ff.writeback_address;

endmodule

[design/sactc_ram.sv]
// Single-port-write, registered-read memory with per-lane write mask.
module sactc_ram #(
   parameter int DEPTH  = 256,
   parameter int AW     = 8,
   parameter int LANES  = 1,
   parameter int LANE_W = 8
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [LANES-1:0]              wr_mask,
   input  logic [LANES-1:0][LANE_W-1:0]  wr_data,
   input  logic                          rd_en,
   input  logic [AW-1:0]                 rd_addr,
   output logic [LANES-1:0][LANE_W-1:0]  rd_data_ff
);

   logic [LANES-1:0][LANE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int l = 0; l < LANES; l++) begin
            if (wr_mask[l]) begin
               mem[wr_addr][l] <= wr_data[l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[design/sactc_decide.sv]
// Way compare, fill/victim choice and row update for one access.
module sactc_decide #(
   parameter int MAX_WAYS = 8,
   parameter int SET_AW   = 8
) (
   input  logic [1:0]                                        command,
   input  sactc_pkg::cfg_type                                cfg,
   input  logic [$clog2(MAX_WAYS+1)-1:0]                     eff_ways,
   input  logic [sactc_pkg::SHIFT_W-1:0]                     shift,
   input  logic [sactc_pkg::ADDR_W-1:0]                      tag,
   input  logic [SET_AW-1:0]                                 set_idx,
   input  logic [MAX_WAYS-1:0]                               valid_row,
   input  logic [MAX_WAYS-1:0]                               dirty_row,
   input  logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] ptr,
   input  logic [MAX_WAYS-1:0][sactc_pkg::ADDR_W-1:0]        tag_row,
   output logic                                              meta_we,
   output logic [MAX_WAYS-1:0]                               valid_new,
   output logic [MAX_WAYS-1:0]                               dirty_new,
   output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] ptr_new,
   output logic [MAX_WAYS-1:0]                               tag_we,
   output sactc_pkg::rsp_type                                res
);

   localparam int PTR_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_CNT_W = $clog2(MAX_WAYS+1);

   logic                 accepted;
   logic                 is_write;
   logic                 hit;
   logic [PTR_W-1:0]     hit_way;
   logic                 free_found;
   logic [PTR_W-1:0]     free_way;
   logic                 stop;
   logic [PTR_W-1:0]     victim;
   logic [WAY_CNT_W-1:0] next_ptr;
   logic [PTR_W-1:0]     fill_way;

   assign is_write = (command == sactc_pkg::CMD_WRITE);

   always_comb begin
      accepted = 1'b1;
      if (command != sactc_pkg::CMD_READ && command != sactc_pkg::CMD_WRITE &&
          command != sactc_pkg::CMD_FETCH) begin
         accepted = 1'b0;
      end else if (cfg.cache_kind == sactc_pkg::KIND_INSTR &&
                   command != sactc_pkg::CMD_FETCH) begin
         accepted = 1'b0;
      end else if (cfg.cache_kind == sactc_pkg::KIND_DATA &&
                   command == sactc_pkg::CMD_FETCH) begin
         accepted = 1'b0;
      end
   end

   // ways fill in order: search stops at the first free way or the first hit
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      stop       = 1'b0;
      for (int j = 0; j < MAX_WAYS; j++) begin
         if (WAY_CNT_W'(j) < eff_ways && !stop) begin
            if (!valid_row[j]) begin
               free_found = 1'b1;
               free_way   = PTR_W'(j);
               stop       = 1'b1;
            end else if (tag_row[j] == tag) begin
               hit     = 1'b1;
               hit_way = PTR_W'(j);
               stop    = 1'b1;
            end
         end
      end
   end

   always_comb begin
      victim = ptr;
      if (WAY_CNT_W'(ptr) >= eff_ways) begin
         victim = '0;
      end
      next_ptr = WAY_CNT_W'(victim) + WAY_CNT_W'(1);
      if (next_ptr >= eff_ways) begin
         next_ptr = '0;
      end
   end

   assign fill_way = free_found ? free_way : victim;

   always_comb begin
      meta_we   = 1'b0;
      valid_new = valid_row;
      dirty_new = dirty_row;
      ptr_new   = ptr;
      tag_we    = '0;
      res       = '0;
      if (accepted) begin
         res.accepted = 1'b1;
         if (hit) begin
            res.hit = 1'b1;
            if (is_write) begin
               dirty_new[hit_way] = 1'b1;
               meta_we            = 1'b1;
            end
         end else if (!is_write || cfg.write_allocate) begin
            meta_we             = 1'b1;
            valid_new[fill_way] = 1'b1;
            dirty_new[fill_way] = is_write;
            tag_we[fill_way]    = 1'b1;
            if (!free_found) begin
               ptr_new = next_ptr[PTR_W-1:0];
               if (dirty_row[victim]) begin
                  res.writeback_valid   = 1'b1;
                  res.writeback_address = (tag_row[victim] << shift) |
                                          (sactc_pkg::ADDR_W'(set_idx) << cfg.offset_bits);
               end
            end
         end
      end
   end

endmodule

[design/sactc_checker.sv]
// Port-level checks of the tag controller, bound to the top level.
`include "set_assoc_cache_tag_controller_assert.svh"

module sactc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_accepted,
   input logic                             rsp_hit,
   input logic                             rsp_writeback_valid,
   input logic [sactc_pkg::ADDR_W-1:0]     rsp_writeback_address
);

   // stalled result beat stays valid and holds its hit flag and write-back address
   `SACTC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_hit) && $stable(rsp_writeback_address))

   // ignored access reports nothing
   `SACTC_ASSERT_NOW(a_ignored_quiet, rsp_valid && !rsp_accepted,
      !rsp_hit && !rsp_writeback_valid && rsp_writeback_address == '0)

   // an eviction only comes from an accepted miss
   `SACTC_ASSERT_NOW(a_wb_on_miss, rsp_valid && rsp_writeback_valid,
      rsp_accepted && !rsp_hit)

   // one access at a time: lookup cycle follows every request beat
   `SACTC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

endmodule

bind set_assoc_cache_tag_controller sactc_checker u_sactc_checker (.*);
